// File: design/ppcs_pkg.sv
// Types and constants for the Peltier polarity changeover sequencer.
// Used by peltier_polarity_changeover_sequencer_unit; depends on nothing.
package ppcs_pkg;

  localparam int DUTY_BITS = 8;
  localparam int TIME_BITS = 16;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Register reset values
  localparam logic [TIME_BITS-1:0] DEAD_TIME_RESET     = TIME_BITS'(500);
  localparam logic [TIME_BITS-1:0] KICK_DURATION_RESET = TIME_BITS'(1000);

  // Input word kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DEAD_TIME     = 1'b0;
  localparam logic CFG_KICK_DURATION = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 heating;
    logic [DUTY_BITS-1:0] peltier_duty;
    logic [DUTY_BITS-1:0] fan_duty;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] peltier_duty_out;
    logic [DUTY_BITS-1:0] fan_duty_out;
    logic                 heating_relay_level;
    logic                 cooling_relay_level;
    logic                 change_pending;
    logic                 kick_running;
    logic                 switched_now;
  } out_word_t;

endpackage

// File: design/peltier_polarity_changeover_sequencer_unit.sv
// Peltier polarity changeover sequencer: top level.
// The result word is registered from its input word when that word is accepted.
// Throughput: one word per cycle; the whole update is one pass of logic on the state.
// The input is ready whenever the result register is empty or being drained.
// Synchronous active-high reset: Peltier and fan duty 0, nothing pending, no kick,
// both relay lines high, dead time 500 ticks, kick duration 1000 ticks.
// Depends on ppcs_pkg.
module peltier_polarity_changeover_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ppcs_pkg::in_word_t item,
  output logic               result_valid,
  input  logic               result_ready,
  output ppcs_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [ppcs_pkg::TIME_BITS-1:0] cfg_data
);
  import ppcs_pkg::*;

  // Configuration registers
  logic [TIME_BITS-1:0] relay_dead_time;
  logic [TIME_BITS-1:0] kick_duration;

  // Sequencer state
  logic                 pending_flag,      pending_flag_next;
  logic                 pending_mode,      pending_mode_next;
  logic [DUTY_BITS-1:0] pending_peltier,   pending_peltier_next;
  logic [DUTY_BITS-1:0] pending_fan,       pending_fan_next;
  logic [TIME_BITS-1:0] dead_time_elapsed, dead_time_elapsed_next;
  logic                 kick_flag,         kick_flag_next;
  logic [TIME_BITS-1:0] kick_remaining,    kick_remaining_next;
  logic [DUTY_BITS-1:0] kick_target,       kick_target_next;
  logic [DUTY_BITS-1:0] peltier_now,       peltier_now_next;
  logic [DUTY_BITS-1:0] fan_now,           fan_now_next;
  logic                 heating_level,     heating_level_next;
  logic                 cooling_level,     cooling_level_next;
  logic                 switched;

  logic accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_dead_time <= DEAD_TIME_RESET;
      kick_duration   <= KICK_DURATION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEAD_TIME:     relay_dead_time <= cfg_data;
        CFG_KICK_DURATION: kick_duration   <= cfg_data;
        default:           relay_dead_time <= relay_dead_time;
      endcase
    end
  end

  // Next state: request latches new mode; tick: kick countdown, then dead-time check
  always_comb begin
    logic [TIME_BITS-1:0] kick_dec;
    logic [TIME_BITS-1:0] elapsed_inc;

    pending_flag_next      = pending_flag;
    pending_mode_next      = pending_mode;
    pending_peltier_next   = pending_peltier;
    pending_fan_next       = pending_fan;
    dead_time_elapsed_next = dead_time_elapsed;
    kick_flag_next         = kick_flag;
    kick_remaining_next    = kick_remaining;
    kick_target_next       = kick_target;
    peltier_now_next       = peltier_now;
    fan_now_next           = fan_now;
    heating_level_next     = heating_level;
    cooling_level_next     = cooling_level;
    switched               = 1'b0;

    kick_dec    = (kick_remaining != '0) ? kick_remaining - 1'b1 : kick_remaining;
    elapsed_inc = (dead_time_elapsed != TIME_MAX) ? dead_time_elapsed + 1'b1
                                                  : dead_time_elapsed;

    if (item.kind == KIND_REQUEST) begin
      // Cut power, latch the new mode, restart dead time
      peltier_now_next       = '0;
      pending_flag_next      = 1'b1;
      pending_mode_next      = item.heating;
      pending_peltier_next   = item.peltier_duty;
      pending_fan_next       = item.fan_duty;
      dead_time_elapsed_next = '0;
    end else begin
      if (kick_flag) begin
        kick_remaining_next = kick_dec;
        if (kick_dec == '0) begin
          kick_flag_next = 1'b0;
          fan_now_next   = kick_target;
        end
      end
      if (pending_flag) begin
        dead_time_elapsed_next = elapsed_inc;
        if (elapsed_inc >= relay_dead_time) begin
          pending_flag_next  = 1'b0;
          switched           = 1'b1;
          // heating: heating line low, cooling line high
          heating_level_next = !pending_mode;
          cooling_level_next = pending_mode;
          peltier_now_next   = pending_peltier;
          if (pending_fan != DUTY_MAX) begin
            kick_flag_next      = 1'b1;
            kick_target_next    = pending_fan;
            kick_remaining_next = kick_duration;
            fan_now_next        = DUTY_MAX;
          end else begin
            fan_now_next = pending_fan;
          end
        end
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag      <= 1'b0;
      pending_mode      <= 1'b0;
      pending_peltier   <= '0;
      pending_fan       <= '0;
      dead_time_elapsed <= '0;
      kick_flag         <= 1'b0;
      kick_remaining    <= '0;
      kick_target       <= '0;
      peltier_now       <= '0;
      fan_now           <= '0;
      heating_level     <= 1'b1;
      cooling_level     <= 1'b1;
      result_valid      <= 1'b0;
    end else begin
      if (accept) begin
        pending_flag      <= pending_flag_next;
        pending_mode      <= pending_mode_next;
        pending_peltier   <= pending_peltier_next;
        pending_fan       <= pending_fan_next;
        dead_time_elapsed <= dead_time_elapsed_next;
        kick_flag         <= kick_flag_next;
        kick_remaining    <= kick_remaining_next;
        kick_target       <= kick_target_next;
        peltier_now       <= peltier_now_next;
        fan_now           <= fan_now_next;
        heating_level     <= heating_level_next;
        cooling_level     <= cooling_level_next;
        result_valid      <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.peltier_duty_out    <= peltier_now_next;
      result.fan_duty_out        <= fan_now_next;
      result.heating_relay_level <= heating_level_next;
      result.cooling_relay_level <= cooling_level_next;
      result.change_pending      <= pending_flag_next;
      result.kick_running        <= kick_flag_next;
      result.switched_now        <= switched;
    end
  end

  // Checks
  a_relays_never_both_low: assert property (@(posedge clk) disable iff (rst)
    heating_level || cooling_level)
    else $error("both relay lines driven low");

  a_request_cuts_power: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_REQUEST |=> peltier_now == '0)
    else $error("Peltier duty not cut on request");

  a_kick_full_duty: assert property (@(posedge clk) disable iff (rst)
    kick_flag |-> fan_now == DUTY_MAX)
    else $error("fan not at full duty during kick");

  a_switch_clears_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.switched_now |-> !result.change_pending && !pending_flag)
    else $error("change still pending after relay switch");

endmodule
